// File: hdl/timebase_schedule_event_matcher_unit_macros.svh
// assertion helpers for the matcher rtl
`ifndef TIMEBASE_SCHEDULE_EVENT_MATCHER_UNIT_MACROS_SVH
`define TIMEBASE_SCHEDULE_EVENT_MATCHER_UNIT_MACROS_SVH

// checked on every clock edge outside reset
`define TSEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define TSEM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/tsem_pkg.sv
`default_nettype none

package tsem_pkg;

  localparam int unsigned TIMEBASE_ENTRIES_DEF = 16;
  localparam int unsigned DAY_PLANS_DEF        = 16;
  localparam int unsigned EVENTS_PER_PLAN_DEF  = 16;

  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_W-1:0] COUNT_RESET = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEBASE_COUNT = 2'd0,
    CFG_PLAN_COUNT     = 2'd1,
    CFG_EVENT_COUNT    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FUNC_WR_TIMEBASE = 2'd0,
    FUNC_WR_EVENT    = 2'd1,
    FUNC_QUERY       = 2'd2
  } func_e;

  // input transaction, last field in the lowest bits
  typedef struct packed {
    logic [5:0]  pad;
    logic [4:0]  now_day;
    logic [2:0]  now_weekday;
    logic [3:0]  now_month;
    logic [15:0] action_code;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [31:0] date_mask;
    logic [7:0]  weekday_mask;
    logic [12:0] month_mask;
    logic [7:0]  plan_number;
    logic [3:0]  entry_index;
    logic [1:0]  func;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [4:0]  fired_event;
    logic [4:0]  fired_plan;
    logic [15:0] fired_action;
    logic        active;
  } out_item_t;

  localparam int unsigned IN_W  = $bits(in_item_t);
  localparam int unsigned OUT_W = $bits(out_item_t);

  typedef struct packed {
    logic [7:0]  plan;
    logic [31:0] date_mask;
    logic [7:0]  weekday_mask;
    logic [12:0] month_mask;
  } tb_entry_t;

  typedef struct packed {
    logic [15:0] action;
    logic [5:0]  minute;
    logic [4:0]  hour;
  } ev_entry_t;

  // date and time of the query in progress
  typedef struct packed {
    logic [3:0] month;
    logic [2:0] weekday;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
  } query_t;

  typedef struct packed {
    logic tb_hit;
    logic ev_time_hit;
    logic ev_repeat;
  } match_t;

endpackage

`default_nettype wire

// File: hdl/tsem_ram.sv
`default_nettype none

module tsem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/tsem_match.sv
`default_nettype none

module tsem_match import tsem_pkg::*; #(
  parameter int unsigned DAY_PLANS = DAY_PLANS_DEF
) (
  input  wire tb_entry_t        tb_entry_i,
  input  wire ev_entry_t        ev_entry_i,
  input  wire query_t           qry_i,
  input  wire logic [CFG_W-1:0] plan_count_i,
  input  wire logic [4:0]       last_plan_i,
  input  wire logic [4:0]       last_event_i,
  input  wire logic [4:0]       cur_plan_i,
  input  wire logic [4:0]       cur_event_i,
  output match_t                match_o
);

  logic [4:0] mon_pos;
  logic [3:0] wd_pos;
  logic       enabled;
  logic       date_hit;
  logic       plan_ok;

  assign mon_pos = 5'(qry_i.month) + 5'd1;
  assign wd_pos  = 4'(qry_i.weekday) + 4'd1;

  assign enabled = (tb_entry_i.month_mask != '0) && (tb_entry_i.weekday_mask != '0) &&
                   (tb_entry_i.date_mask != '0) && (tb_entry_i.plan != '0);

  // positions past the mask width never match
  assign date_hit = (mon_pos < 5'd13) && tb_entry_i.month_mask[mon_pos[3:0]] &&
                    (wd_pos < 4'd8) && tb_entry_i.weekday_mask[wd_pos[2:0]] &&
                    tb_entry_i.date_mask[qry_i.day];

  assign plan_ok = (9'(tb_entry_i.plan) <= 9'(plan_count_i)) &&
                   (9'(tb_entry_i.plan) <= 9'(DAY_PLANS));

  assign match_o.tb_hit      = enabled && date_hit && plan_ok;
  assign match_o.ev_time_hit = (ev_entry_i.hour == qry_i.hour) &&
                               (ev_entry_i.minute == qry_i.minute);
  assign match_o.ev_repeat   = (last_plan_i == cur_plan_i) && (last_event_i == cur_event_i);

endmodule

`default_nettype wire

// File: hdl/tsem_seq.sv
`default_nettype none

`include "timebase_schedule_event_matcher_unit_macros.svh"

module tsem_seq import tsem_pkg::*; #(
  parameter int unsigned TIMEBASE_ENTRIES = TIMEBASE_ENTRIES_DEF,
  parameter int unsigned DAY_PLANS        = DAY_PLANS_DEF,
  parameter int unsigned EVENTS_PER_PLAN  = EVENTS_PER_PLAN_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_item_o,
  input  wire logic [CFG_W-1:0] tb_count_i,
  input  wire logic [CFG_W-1:0] plan_count_i,
  input  wire logic [CFG_W-1:0] ev_count_i
);

  localparam int unsigned EV_SLOTS = DAY_PLANS * EVENTS_PER_PLAN;
  localparam int unsigned TB_AW = (TIMEBASE_ENTRIES > 1) ? $clog2(TIMEBASE_ENTRIES) : 1;
  localparam int unsigned EV_AW = (EV_SLOTS > 1) ? $clog2(EV_SLOTS) : 1;
  localparam int unsigned TB_CW = $clog2(TIMEBASE_ENTRIES + 1);
  localparam int unsigned EV_JW = $clog2(EVENTS_PER_PLAN + 1);
  localparam int unsigned CLR_N = (EV_SLOTS > TIMEBASE_ENTRIES) ? EV_SLOTS : TIMEBASE_ENTRIES;
  localparam int unsigned CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TB_CHK,
    ST_EV_CHK,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [CLR_W-1:0]   clr_q, clr_d;
  logic [TB_CW-1:0]   tb_idx_q, tb_idx_d;
  logic [EV_JW-1:0]   j_q, j_d;
  logic [EV_AW-1:0]   ev_addr_q, ev_addr_d;
  logic [7:0]         plan_q, plan_d;
  query_t             qry_q, qry_d;
  logic [4:0]         last_plan_q, last_plan_d;
  logic [4:0]         last_event_q, last_event_d;
  out_item_t          res_q, res_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               in_hs;
  logic [8:0]         tb_n;
  logic [8:0]         ev_n;
  logic [TB_CW-1:0]   tb_inc;
  logic [EV_JW-1:0]   j_inc;
  logic [4:0]         cur_event;
  logic [7:0]         mult_plan;
  logic [EV_AW-1:0]   slot_base;
  logic               clearing;
  logic               wr_tb;
  logic               wr_ev;
  logic               plan_end;

  logic               tb_we;
  logic [TB_AW-1:0]   tb_waddr;
  tb_entry_t          tb_wdata;
  tb_entry_t          tb_rdata;
  logic               ev_we;
  logic [EV_AW-1:0]   ev_waddr;
  ev_entry_t          ev_wdata;
  ev_entry_t          ev_rdata;
  match_t             match;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_hs       = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // scan lengths saturate at the table sizes
  assign tb_n = (9'(tb_count_i) < 9'(TIMEBASE_ENTRIES)) ? 9'(tb_count_i) : 9'(TIMEBASE_ENTRIES);
  assign ev_n = (9'(ev_count_i) < 9'(EVENTS_PER_PLAN)) ? 9'(ev_count_i) : 9'(EVENTS_PER_PLAN);

  assign tb_inc    = tb_idx_q + TB_CW'(1);
  assign j_inc     = j_q + EV_JW'(1);
  assign cur_event = 5'(j_inc);

  // one slot-base multiplier, shared by event writes and the plan scan
  assign mult_plan = (state_q == ST_IDLE) ? in_item_i.plan_number : tb_rdata.plan;
  assign slot_base = EV_AW'(32'(mult_plan - 8'd1) * 32'(EVENTS_PER_PLAN));

  assign clearing = (state_q == ST_CLEAR);

  assign wr_tb = in_hs && (in_item_i.func == FUNC_WR_TIMEBASE) &&
                 (9'(in_item_i.entry_index) < 9'(TIMEBASE_ENTRIES));
  assign wr_ev = in_hs && (in_item_i.func == FUNC_WR_EVENT) &&
                 (in_item_i.plan_number != '0) &&
                 (9'(in_item_i.plan_number) <= 9'(DAY_PLANS)) &&
                 (9'(in_item_i.entry_index) < 9'(EVENTS_PER_PLAN));

  always_comb begin
    tb_we    = clearing ? (17'(clr_q) < 17'(TIMEBASE_ENTRIES)) : wr_tb;
    tb_waddr = clearing ? TB_AW'(clr_q) : TB_AW'(in_item_i.entry_index);
    tb_wdata = '0;
    ev_we    = clearing ? (17'(clr_q) < 17'(EV_SLOTS)) : wr_ev;
    ev_waddr = clearing ? EV_AW'(clr_q) : (slot_base + EV_AW'(in_item_i.entry_index));
    ev_wdata = '0;
    if (!clearing) begin
      tb_wdata = '{plan:         in_item_i.plan_number,
                   date_mask:    in_item_i.date_mask,
                   weekday_mask: in_item_i.weekday_mask,
                   month_mask:   in_item_i.month_mask};
      ev_wdata = '{action: in_item_i.action_code,
                   minute: in_item_i.minute,
                   hour:   in_item_i.hour};
    end
  end

  tsem_ram #(
    .WIDTH ($bits(tb_entry_t)),
    .DEPTH (TIMEBASE_ENTRIES)
  ) u_tb_ram (
    .clk_i   (clk_i),
    .we_i    (tb_we),
    .waddr_i (tb_waddr),
    .wdata_i (tb_wdata),
    .raddr_i (tb_idx_d[TB_AW-1:0]),
    .rdata_o (tb_rdata)
  );

  tsem_ram #(
    .WIDTH ($bits(ev_entry_t)),
    .DEPTH (EV_SLOTS)
  ) u_ev_ram (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (ev_waddr),
    .wdata_i (ev_wdata),
    .raddr_i (ev_addr_d),
    .rdata_o (ev_rdata)
  );

  tsem_match #(
    .DAY_PLANS (DAY_PLANS)
  ) u_match (
    .tb_entry_i   (tb_rdata),
    .ev_entry_i   (ev_rdata),
    .qry_i        (qry_q),
    .plan_count_i (plan_count_i),
    .last_plan_i  (last_plan_q),
    .last_event_i (last_event_q),
    .cur_plan_i   (plan_q[4:0]),
    .cur_event_i  (cur_event),
    .match_o      (match)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    tb_idx_d     = tb_idx_q;
    j_d          = j_q;
    ev_addr_d    = ev_addr_q;
    plan_d       = plan_q;
    qry_d        = qry_q;
    last_plan_d  = last_plan_q;
    last_event_d = last_event_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    plan_end     = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_W'(CLR_N - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + CLR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_hs) begin
          res_d = '0;
          if (in_item_i.func == FUNC_QUERY) begin
            qry_d = '{month:   in_item_i.now_month,
                      weekday: in_item_i.now_weekday,
                      day:     in_item_i.now_day,
                      hour:    in_item_i.hour,
                      minute:  in_item_i.minute};
            tb_idx_d = '0;
            state_d  = (tb_n == '0) ? ST_DONE : ST_TB_CHK;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_TB_CHK: begin
        if (match.tb_hit && (ev_n != '0)) begin
          plan_d    = tb_rdata.plan;
          ev_addr_d = slot_base;
          j_d       = '0;
          state_d   = ST_EV_CHK;
        end else if (9'(tb_inc) == tb_n) begin
          state_d = ST_DONE;
        end else begin
          tb_idx_d = tb_inc;
        end
      end
      ST_EV_CHK: begin
        if (match.ev_time_hit) begin
          if (!match.ev_repeat) begin
            if (ev_rdata.action != '0) begin
              res_d.active       = 1'b1;
              res_d.fired_action = ev_rdata.action;
              res_d.fired_plan   = plan_q[4:0];
              res_d.fired_event  = cur_event;
              last_plan_d        = plan_q[4:0];
              last_event_d       = cur_event;
            end
          end else begin
            // repeat of the last fired event ends this plan
            plan_end = 1'b1;
          end
        end else begin
          last_plan_d  = '0;
          last_event_d = '0;
        end
        if (9'(j_inc) == ev_n) begin
          plan_end = 1'b1;
        end
        if (plan_end) begin
          if (res_d.active) begin
            state_d = ST_DONE;
          end else if (9'(tb_inc) == tb_n) begin
            state_d = ST_DONE;
          end else begin
            tb_idx_d = tb_inc;
            state_d  = ST_TB_CHK;
          end
        end else begin
          j_d       = j_inc;
          ev_addr_d = ev_addr_q + EV_AW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      tb_idx_q     <= '0;
      j_q          <= '0;
      ev_addr_q    <= '0;
      plan_q       <= '0;
      qry_q        <= '0;
      last_plan_q  <= '0;
      last_event_q <= '0;
      res_q        <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      tb_idx_q     <= tb_idx_d;
      j_q          <= j_d;
      ev_addr_q    <= ev_addr_d;
      plan_q       <= plan_d;
      qry_q        <= qry_d;
      last_plan_q  <= last_plan_d;
      last_event_q <= last_event_d;
      res_q        <= res_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  `TSEM_ASSERT(a_accept_leaves_idle, in_hs |=> !in_ready_o, "accepted transaction did not start work")
  `TSEM_ASSERT(a_quiet_result_zero, out_valid_q && !out_q.active |-> (out_q.fired_action == '0) && (out_q.fired_plan == '0) && (out_q.fired_event == '0), "result without firing carries data")
  `TSEM_ASSERT(a_fired_action_set, out_valid_q && out_q.active |-> out_q.fired_action != '0, "fired result with empty action")
  `TSEM_ASSERT(a_event_scan_bound, state_q == ST_EV_CHK |-> 9'(j_q) < ev_n, "event scan past event count")
  `TSEM_ASSERT_ALWAYS(a_done_holds, rst_ni && state_q == ST_DONE && out_valid_q && !out_ready_i |=> state_q == ST_DONE || !rst_ni, "result dropped while output stalled")

endmodule

`default_nettype wire

// File: hdl/timebase_schedule_event_matcher_unit.sv
// channel  | direction | handshake                     | payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready | table write or query transaction
// m_axis   | out       | m_axis_tvalid / m_axis_tready | one result per input transaction
// cfg      | in        | cfg_we_i (no wait)            | cfg_idx_i selects, cfg_data_i value
//
// after reset a clearing pass zeroes both tables over
//   max(TIMEBASE_ENTRIES, DAY_PLANS * EVENTS_PER_PLAN) slots (256 by default), not ready meanwhile
// a write is stored as it is taken and answered from the done state; a query walks the timebase
//   entries, scans the events of each matching plan, and stops at the first event that fires
// scans read one entry at a time via each table's single read port and the one shared compare unit
// a new transaction is taken while the previous result still waits on m_axis
`default_nettype none

module timebase_schedule_event_matcher_unit import tsem_pkg::*; #(
  parameter int unsigned TIMEBASE_ENTRIES = TIMEBASE_ENTRIES_DEF,
  parameter int unsigned DAY_PLANS        = DAY_PLANS_DEF,
  parameter int unsigned EVENTS_PER_PLAN  = EVENTS_PER_PLAN_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // func, entry_index, plan_number, month_mask, weekday_mask, date_mask, hour, minute,
  // action_code, now_month, now_weekday, now_day, zero fill
  input  wire logic [IN_W-1:0]      s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // active, fired_action, fired_plan, fired_event, zero fill
  output logic      [OUT_W-1:0]     m_axis_tdata,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  logic [CFG_W-1:0] tb_count_q;
  logic [CFG_W-1:0] plan_count_q;
  logic [CFG_W-1:0] ev_count_q;
  in_item_t         in_item;
  out_item_t        out_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tb_count_q   <= COUNT_RESET;
      plan_count_q <= COUNT_RESET;
      ev_count_q   <= COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMEBASE_COUNT: tb_count_q   <= cfg_data_i;
        CFG_PLAN_COUNT:     plan_count_q <= cfg_data_i;
        CFG_EVENT_COUNT:    ev_count_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_item      = in_item_t'(s_axis_tdata);
  assign m_axis_tdata = OUT_W'(out_item);

  tsem_seq #(
    .TIMEBASE_ENTRIES (TIMEBASE_ENTRIES),
    .DAY_PLANS        (DAY_PLANS),
    .EVENTS_PER_PLAN  (EVENTS_PER_PLAN)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_item_o   (out_item),
    .tb_count_i   (tb_count_q),
    .plan_count_i (plan_count_q),
    .ev_count_i   (ev_count_q)
  );

endmodule

`default_nettype wire
